FILE: hdl/button_gesture_classifier_unit_assert.svh
// assertion macros for the button gesture classifier
// used by the top level only; needs clk and rst_n in the including scope
`ifndef BUTTON_GESTURE_CLASSIFIER_UNIT_ASSERT_SVH
`define BUTTON_GESTURE_CLASSIFIER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define BGC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bgc: same-cycle check failed");
// next-cycle implication
`define BGC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bgc: next-cycle check failed");
`else
`define BGC_ASSERT_IMPL(label, ante, cons)
`define BGC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: hdl/bgc_pkg.sv
// shared types and constants for the button gesture classifier
// no dependencies; used by all modules by scoped names
package bgc_pkg;

    localparam int TICK_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int S_TDATA_W = 40;   // pin_level + now_ticks, padded to bytes
    localparam int M_TDATA_W = 8;    // event_kind + fsm_phase, padded to bytes

    // register reset values
    localparam logic [TICK_W-1:0] CLICK_MIN_RST     = 32'd20;
    localparam logic [TICK_W-1:0] CLICK_MAX_RST     = 32'd500;
    localparam logic [TICK_W-1:0] LONG_MIN_RST      = 32'd1000;
    localparam logic [TICK_W-1:0] LONG_MAX_RST      = 32'd3000;
    localparam logic [TICK_W-1:0] LONGLONG_MIN_RST  = 32'd3001;
    localparam logic [TICK_W-1:0] LONGLONG_MAX_RST  = 32'd10000;
    localparam logic [TICK_W-1:0] DOUBLE_WINDOW_RST = 32'd300;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        IDX_CLICK_MIN     = 3'd0,
        IDX_CLICK_MAX     = 3'd1,
        IDX_LONG_MIN      = 3'd2,
        IDX_LONG_MAX      = 3'd3,
        IDX_LONGLONG_MIN  = 3'd4,
        IDX_LONGLONG_MAX  = 3'd5,
        IDX_DOUBLE_WINDOW = 3'd6
    } cfg_idx_t;

    // state machine phases
    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_PRESSED  = 3'd1,
        PH_RELEASED = 3'd2,
        PH_IDENTIFY = 3'd3,
        PH_EMIT_CLK = 3'd4,
        PH_EMIT_LP  = 3'd5,
        PH_EMIT_LLP = 3'd6
    } phase_t;

    // gesture events
    typedef enum logic [2:0] {
        EV_NONE  = 3'd0,
        EV_CLICK = 3'd1,
        EV_DBL   = 3'd2,
        EV_LONG  = 3'd3,
        EV_LLONG = 3'd4
    } event_t;

    // configuration bundle from the register file to the core
    typedef struct packed {
        logic [TICK_W-1:0] click_min;
        logic [TICK_W-1:0] click_max;
        logic [TICK_W-1:0] long_min;
        logic [TICK_W-1:0] long_max;
        logic [TICK_W-1:0] longlong_min;
        logic [TICK_W-1:0] longlong_max;
        logic [TICK_W-1:0] double_window;
    } cfg_t;

endpackage

FILE: hdl/bgc_cfg_regs.sv
// configuration register file for the button gesture classifier
// depends on bgc_pkg
module bgc_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bgc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bgc_pkg::TICK_W-1:0]    cfg_wdata,
    output bgc_pkg::cfg_t                 cfg
);

    bgc_pkg::cfg_t cfg_reg;
    bgc_pkg::cfg_t cfg_next;

    // decode the write; unknown index is dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (bgc_pkg::cfg_idx_t'(cfg_index))
                bgc_pkg::IDX_CLICK_MIN:     cfg_next.click_min     = cfg_wdata;
                bgc_pkg::IDX_CLICK_MAX:     cfg_next.click_max     = cfg_wdata;
                bgc_pkg::IDX_LONG_MIN:      cfg_next.long_min      = cfg_wdata;
                bgc_pkg::IDX_LONG_MAX:      cfg_next.long_max      = cfg_wdata;
                bgc_pkg::IDX_LONGLONG_MIN:  cfg_next.longlong_min  = cfg_wdata;
                bgc_pkg::IDX_LONGLONG_MAX:  cfg_next.longlong_max  = cfg_wdata;
                bgc_pkg::IDX_DOUBLE_WINDOW: cfg_next.double_window = cfg_wdata;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    // register storage with reset defaults
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.click_min     <= bgc_pkg::CLICK_MIN_RST;
            cfg_reg.click_max     <= bgc_pkg::CLICK_MAX_RST;
            cfg_reg.long_min      <= bgc_pkg::LONG_MIN_RST;
            cfg_reg.long_max      <= bgc_pkg::LONG_MAX_RST;
            cfg_reg.longlong_min  <= bgc_pkg::LONGLONG_MIN_RST;
            cfg_reg.longlong_max  <= bgc_pkg::LONGLONG_MAX_RST;
            cfg_reg.double_window <= bgc_pkg::DOUBLE_WINDOW_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hdl/bgc_core.sv
// gesture state machine: one pass per advanced transaction
// depends on bgc_pkg; fed by bgc_cfg_regs
module bgc_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  bgc_pkg::cfg_t              cfg,
    input  logic                       adv,
    input  logic                       pin_level,
    input  logic [bgc_pkg::TICK_W-1:0] now_ticks,
    output bgc_pkg::event_t            res_event,
    output bgc_pkg::phase_t            res_phase,
    output bgc_pkg::phase_t            state_phase
);

    bgc_pkg::phase_t             phase_reg, phase_next;
    logic [bgc_pkg::TICK_W-1:0]  press_start_reg, press_start_next;
    logic [bgc_pkg::TICK_W-1:0]  press_length_reg, press_length_next;
    logic [bgc_pkg::TICK_W-1:0]  last_click_reg, last_click_next;
    bgc_pkg::event_t             pending_reg, pending_next;

    logic [bgc_pkg::TICK_W-1:0]  held_ticks;
    logic [bgc_pkg::TICK_W-1:0]  since_click;
    logic                        in_click, in_long, in_longlong;

    // modulo 2^32 differences and window tests
    assign held_ticks  = now_ticks - press_start_reg;
    assign since_click = now_ticks - last_click_reg;
    assign in_click    = (press_length_reg >= cfg.click_min) &&
                         (press_length_reg <= cfg.click_max);
    assign in_long     = (press_length_reg >= cfg.long_min) &&
                         (press_length_reg <= cfg.long_max);
    assign in_longlong = (press_length_reg >= cfg.longlong_min) &&
                         (press_length_reg <= cfg.longlong_max);

    // next state
    always_comb
    begin
        phase_next        = phase_reg;
        press_start_next  = press_start_reg;
        press_length_next = press_length_reg;
        last_click_next   = last_click_reg;
        pending_next      = pending_reg;
        unique case (phase_reg)
            bgc_pkg::PH_IDLE:
            begin
                if (pin_level)
                begin
                    press_start_next = now_ticks;
                    phase_next       = bgc_pkg::PH_PRESSED;
                end
            end
            bgc_pkg::PH_PRESSED:
            begin
                if (!pin_level)
                begin
                    press_length_next = held_ticks;
                    phase_next        = bgc_pkg::PH_RELEASED;
                end
            end
            bgc_pkg::PH_RELEASED:
            begin
                priority if (in_click)
                begin
                    phase_next = bgc_pkg::PH_IDENTIFY;
                end
                else if (in_long)
                begin
                    pending_next = bgc_pkg::EV_LONG;
                    phase_next   = bgc_pkg::PH_EMIT_LP;
                end
                else if (in_longlong)
                begin
                    pending_next = bgc_pkg::EV_LLONG;
                    phase_next   = bgc_pkg::PH_EMIT_LLP;
                end
                else
                begin
                    phase_next = bgc_pkg::PH_IDLE;
                end
            end
            bgc_pkg::PH_IDENTIFY:
            begin
                if (since_click > cfg.double_window)
                begin
                    last_click_next = now_ticks;
                    pending_next    = bgc_pkg::EV_CLICK;
                end
                else
                begin
                    pending_next = bgc_pkg::EV_DBL;
                end
                phase_next = bgc_pkg::PH_EMIT_CLK;
            end
            bgc_pkg::PH_EMIT_CLK, bgc_pkg::PH_EMIT_LP, bgc_pkg::PH_EMIT_LLP:
            begin
                pending_next = bgc_pkg::EV_NONE;
                phase_next   = bgc_pkg::PH_IDLE;
            end
            default:
            begin
                phase_next = bgc_pkg::PH_IDLE;
            end
        endcase
    end

    // outputs of this pass
    always_comb
    begin
        unique case (phase_reg)
            bgc_pkg::PH_EMIT_CLK, bgc_pkg::PH_EMIT_LP, bgc_pkg::PH_EMIT_LLP:
                res_event = pending_reg;
            default:
                res_event = bgc_pkg::EV_NONE;
        endcase
    end

    assign res_phase   = phase_next;
    assign state_phase = phase_reg;

    // state registers, updated only when a transaction advances
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= bgc_pkg::PH_IDLE;
            press_start_reg  <= '0;
            press_length_reg <= '0;
            last_click_reg   <= '0;
            pending_reg      <= bgc_pkg::EV_NONE;
        end
        else if (adv)
        begin
            phase_reg        <= phase_next;
            press_start_reg  <= press_start_next;
            press_length_reg <= press_length_next;
            last_click_reg   <= last_click_next;
            pending_reg      <= pending_next;
        end
    end

endmodule

FILE: hdl/button_gesture_classifier_unit.sv
// button gesture classifier top level: input register, core, output register
// depends on bgc_pkg, bgc_cfg_regs, bgc_core, button_gesture_classifier_unit_assert.svh
//
// usage:
//   s_* stream carries one state-machine pass per transaction: the qualified
//   button level and a free-running 32-bit tick stamp. m_* stream returns
//   exactly one result per pass: the emitted event (none, click, double
//   click, long press, long-long press) and the phase after the pass.
//   cfg_we/cfg_index/cfg_wdata write the seven window registers; write only
//   while no transaction is in flight. an index above six is ignored.
// throughput: one transaction per cycle while m_tready is high, set by the
//   single-pass state update between the input register and the output register.
// path: an input transaction is held in the input register, then its result
//   is held in the output register.
// reset: phase idle, timestamps zero, windows at their defaults, both
//   stages empty.
// stall: when m_tready is low the result holds; one more input is taken
//   into the input register, after which s_tready drops until the output
//   drains.
`include "button_gesture_classifier_unit_assert.svh"

module button_gesture_classifier_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    // slave stream; tdata: [0] pin_level, [32:1] now_ticks, [39:33] zero
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bgc_pkg::S_TDATA_W-1:0]  s_tdata,
    // master stream; tdata: [2:0] event_kind, [5:3] fsm_phase, [7:6] zero
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bgc_pkg::M_TDATA_W-1:0]  m_tdata,
    // configuration write port
    input  logic                           cfg_we,
    input  logic [bgc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bgc_pkg::TICK_W-1:0]     cfg_wdata
);

    logic                        in_valid_reg, in_valid_next;
    logic                        in_pin_reg;
    logic [bgc_pkg::TICK_W-1:0]  in_now_reg;
    logic                        out_valid_reg, out_valid_next;
    bgc_pkg::event_t             out_event_reg;
    bgc_pkg::phase_t             out_phase_reg;

    logic                        adv;
    logic                        s_accept;
    bgc_pkg::cfg_t               cfg;
    bgc_pkg::event_t             res_event;
    bgc_pkg::phase_t             res_phase;
    bgc_pkg::phase_t             state_phase;
    logic                        core_emit;
    logic                        out_event_seen;

    // handshake: a pass advances when the input register holds one and the output register is free or draining
    assign adv      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
            in_valid_next = 1'b1;
        else if (adv)
            in_valid_next = 1'b0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (adv)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input payload register
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_pin_reg <= s_tdata[0];
            in_now_reg <= s_tdata[bgc_pkg::TICK_W:1];
        end
    end

    // output payload register
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_event_reg <= res_event;
            out_phase_reg <= res_phase;
        end
    end

    bgc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bgc_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .adv         (adv),
        .pin_level   (in_pin_reg),
        .now_ticks   (in_now_reg),
        .res_event   (res_event),
        .res_phase   (res_phase),
        .state_phase (state_phase)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_phase_reg, out_event_reg};

    // check helpers: core sits in an emit phase, output carries an event
    assign core_emit      = (state_phase == bgc_pkg::PH_EMIT_CLK) ||
                            (state_phase == bgc_pkg::PH_EMIT_LP) ||
                            (state_phase == bgc_pkg::PH_EMIT_LLP);
    assign out_event_seen = m_tvalid && (out_event_reg != bgc_pkg::EV_NONE);

    // an event is only reported on the pass that returns to idle
    `BGC_ASSERT_IMPL(a_event_on_idle, out_event_seen, out_phase_reg == bgc_pkg::PH_IDLE)
    // emit phases always fall back to idle after one pass
    `BGC_ASSERT_NEXT(a_emit_to_idle, adv && core_emit, state_phase == bgc_pkg::PH_IDLE)
    // reported phase tracks the core state after each pass
    `BGC_ASSERT_NEXT(a_phase_tracks, adv, out_phase_reg == state_phase)
    // input stage never overwritten while holding an unprocessed pass
    `BGC_ASSERT_IMPL(a_no_overrun, s_accept && in_valid_reg, adv)

endmodule
